/* sv/rti_pkg.sv */
// rti_pkg: widths, register codes, pipeline structs and the divider step
// shared by the ray/triangle intersection pipeline. No dependencies.
package rti_pkg;

    // coordinate format
    localparam int CW  = 21;           // coordinate width, signed
    localparam int FB  = 12;           // coordinate fraction bits
    localparam int UVB = 24;           // barycentric fraction bits
    localparam int QB  = 31;           // quotient bits produced by the divider
    localparam int NL  = 3;            // divider lanes: u, v, t

    // arithmetic widths
    localparam int EW  = CW + 1;       // edges and origin offset
    localparam int PW  = 2 * EW;       // cross product term
    localparam int XW  = PW + 1;       // cross product component
    localparam int LB  = (XW + 1) / 2; // low slice of a split multiply
    localparam int HB  = XW - LB;      // high slice of a split multiply
    localparam int PLW = EW + LB + 1;
    localparam int PHW = EW + HB;
    localparam int PRW = EW + XW;      // full dot product term
    localparam int DW  = PRW + 2;      // dot product sum
    localparam int SHU = QB - UVB;     // divisor alignment for u and v
    localparam int SHT = QB - FB;      // divisor alignment for t
    localparam int RW  = DW + SHT + 1; // divider remainder

    // configuration
    localparam int VW   = 3 * CW;
    localparam int THW  = 20;
    localparam int LSH  = 3 * FB - 24;
    localparam int LIMW = THW + LSH;
    localparam int AW   = 5;
    localparam int PDW  = 64;
    localparam logic [THW-1:0] THR_RESET = THW'(1678);

    // stream and result widths
    localparam int IDW = 128;
    localparam int ODW = 128;
    localparam int DSW = 31;
    localparam int HW  = 32;
    localparam int HMW = CW + DSW + 1;
    localparam int HSW = HMW + 1;

    localparam logic [QB-1:0]  UV_ONE   = QB'(1) << UVB;
    localparam logic [DSW-1:0] DIST_MAX = '1;

    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int LANE_T = 2;

    typedef enum logic [1:0] {
        REG_VERTEX_ZERO,
        REG_VERTEX_ONE,
        REG_VERTEX_TWO,
        REG_THRESHOLD
    } rti_reg_t;

    // ray data and early flags that ride alongside the divider
    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] d;
        logic [NL-1:0]      neg;
        logic [NL-1:0]      ovf;
        logic               par_miss;
    } rti_side_t;

    typedef struct packed {
        logic [NL-1:0][RW-1:0] rem;
        logic [DW-1:0]         den;
        rti_side_t             side;
    } rti_div_in_t;

    typedef struct packed {
        logic [NL-1:0][RW-1:0] rem;
        logic [NL-1:0][QB-1:0] quo;
        logic [DW-1:0]         den;
        rti_side_t             side;
    } rti_div_stage_t;

    typedef struct packed {
        logic [NL-1:0][QB-1:0] quo;
        rti_side_t             side;
    } rti_div_out_t;

    // divisor aligned so that the quotient lands in QB bits
    function automatic logic [RW-1:0] lane_div(input logic [DW-1:0] den, input int lane);
        logic [RW-1:0] wide;
        wide = RW'(den);
        return (lane == LANE_T) ? (wide << SHT) : (wide << SHU);
    endfunction

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                             input logic [RW-1:0] dvs);
        logic [RW-1:0] dbl;
        logic          ge;
        dbl = rem << 1;
        ge  = (dbl >= dvs);
        return {ge, ge ? (dbl - dvs) : dbl};
    endfunction

endpackage

/* sv/rti_div.sv */
// rti_div: pipelined restoring divider, one quotient bit per stage, three
// lanes (u, v, t) sharing one divisor. Depends on rti_pkg.
module rti_div
    import rti_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  rti_div_in_t  in_data,
    output logic         out_vld,
    output rti_div_out_t out_data
);

    rti_div_stage_t stg_reg  [QB];
    rti_div_stage_t stg_next [QB];
    rti_div_stage_t in_stg;
    logic [QB-1:0]  vld_reg;

    always_comb
    begin
        in_stg.rem  = in_data.rem;
        in_stg.quo  = '0;
        in_stg.den  = in_data.den;
        in_stg.side = in_data.side;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        rti_div_stage_t src;
        rti_div_stage_t nxt;

        if (s == 0)
        begin : g_first
            assign src = in_stg;
        end
        else
        begin : g_rest
            assign src = stg_reg[s-1];
        end

        always_comb
        begin
            logic [RW:0] res;
            nxt = src;
            for (int l = 0; l < NL; l++)
            begin
                res         = div_step(src.rem[l], lane_div(src.den, l));
                nxt.rem[l]  = res[RW-1:0];
                nxt.quo[l]  = {src.quo[l][QB-2:0], res[RW]};
            end
        end

        assign stg_next[s] = nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QB; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign out_vld       = vld_reg[QB-1];
    assign out_data.quo  = stg_reg[QB-1].quo;
    assign out_data.side = stg_reg[QB-1].side;

endmodule

/* sv/ray_triangle_intersect_unit.sv */
// ray_triangle_intersect_unit: top level of the Moller-Trumbore ray/triangle
// test. Depends on rti_pkg and rti_div.

// One ray per request, one result per request, in order. The triangle is held
// in four registers (three packed vertices and the parallel threshold). The
// user must write it over the APB port only while no ray is in flight; the
// block does not enforce this. The pipeline takes a new ray every clock unless
// the result side stalls. It has eight stages of edge, cross and dot arithmetic
// (dot product multiplies split into two partial products to keep each below
// 32x32), 31 stages of the shared restoring divider that forms u, v and t
// one quotient bit per stage, and three stages for hit classification, the
// hit-point multiply and the saturating add into the output register. A stall
// on the result side holds the whole pipeline; input ready follows it directly.
// Result tdata: hit, distance (Q19.12), hit x, y, z (Q19.12, saturated);
// everything but hit reads zero on a miss.
module ray_triangle_intersect_unit
    import rti_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    // ray requests
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [IDW-1:0] s_axis_tdata,   // origin_x, origin_y, origin_z,
                                           // direction_x, direction_y,
                                           // direction_z, 2 bits zero pad
    // results
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [ODW-1:0] m_axis_tdata,   // hit, distance, hit_x, hit_y, hit_z
    // configuration
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [AW-1:0]  paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VW-1:0]  v0_reg, v1_reg, v2_reg;
    logic [THW-1:0] thr_reg;
    rti_reg_t       cfg_idx;
    logic           cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = rti_reg_t'(paddr[AW-1:3]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= '0;
            v1_reg  <= '0;
            v2_reg  <= '0;
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_VERTEX_ZERO: v0_reg  <= pwdata[VW-1:0];
                REG_VERTEX_ONE:  v1_reg  <= pwdata[VW-1:0];
                REG_VERTEX_TWO:  v2_reg  <= pwdata[VW-1:0];
                REG_THRESHOLD:   thr_reg <= pwdata[THW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_VERTEX_ZERO: prdata = PDW'(v0_reg);
            REG_VERTEX_ONE:  prdata = PDW'(v1_reg);
            REG_VERTEX_TWO:  prdata = PDW'(v2_reg);
            REG_THRESHOLD:   prdata = PDW'(thr_reg);
        endcase
    end

    // triangle edges, which the user must keep static while rays are in flight (not enforced here)
    logic signed [CW-1:0] v0 [3];
    logic signed [CW-1:0] v1 [3];
    logic signed [CW-1:0] v2 [3];
    logic signed [EW-1:0] e1 [3];
    logic signed [EW-1:0] e2 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v0[i] = $signed(v0_reg[i*CW +: CW]);
            v1[i] = $signed(v1_reg[i*CW +: CW]);
            v2[i] = $signed(v2_reg[i*CW +: CW]);
            e1[i] = EW'(v1[i]) - EW'(v0[i]);
            e2[i] = EW'(v2[i]) - EW'(v0[i]);
        end
    end

    // ------------------------------------------------------------------
    // handshake: the whole pipeline advances unless a result is held
    // ------------------------------------------------------------------
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [CW-1:0] in_o [3];
    logic signed [CW-1:0] in_d [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_o[i] = $signed(s_axis_tdata[i*CW +: CW]);
            in_d[i] = $signed(s_axis_tdata[(3+i)*CW +: CW]);
        end
    end

    // ------------------------------------------------------------------
    // front stages
    // ------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;

    logic signed [CW-1:0] s1_o_reg [3], s2_o_reg [3], s3_o_reg [3], s4_o_reg [3];
    logic signed [CW-1:0] s5_o_reg [3], s6_o_reg [3], s7_o_reg [3];
    logic signed [CW-1:0] s1_d_reg [3], s2_d_reg [3], s3_d_reg [3], s4_d_reg [3];
    logic signed [CW-1:0] s5_d_reg [3], s6_d_reg [3], s7_d_reg [3];
    logic signed [EW-1:0] s1_t_reg [3], s2_t_reg [3], s3_t_reg [3];

    logic signed [PW-1:0]  s2_pa_reg [3], s2_pb_reg [3];
    logic signed [PW-1:0]  s2_qa_reg [3], s2_qb_reg [3];
    logic signed [XW-1:0]  s3_p_reg [3], s3_q_reg [3];
    logic signed [PLW-1:0] s4_pl_reg [4][3];
    logic signed [PHW-1:0] s4_ph_reg [4][3];
    logic signed [PRW-1:0] s5_pr_reg [4][3];
    logic signed [DW-1:0]  s6_sum_reg [4];   // det, T.p, D.q, e2.q
    logic [DW-1:0]         s7_mag_reg [4];
    logic [3:0]            s7_neg_reg;
    rti_div_in_t           s8_next, s8_reg;

    // dot product operands
    logic signed [EW-1:0] dot_a [4][3];
    logic signed [XW-1:0] dot_b [4][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_a[0][i] = e1[i];
            dot_b[0][i] = s3_p_reg[i];
            dot_a[1][i] = s3_t_reg[i];
            dot_b[1][i] = s3_p_reg[i];
            dot_a[2][i] = EW'(s3_d_reg[i]);
            dot_b[2][i] = s3_q_reg[i];
            dot_a[3][i] = e2[i];
            dot_b[3][i] = s3_q_reg[i];
        end
    end

    // divider set-up: parallel test, sign of each quotient, overflow of the
    // quotient field
    logic [LIMW-1:0] limit;

    always_comb
    begin
        limit       = LIMW'(thr_reg) << LSH;
        s8_next.den = s7_mag_reg[0];
        s8_next.side.par_miss = (s7_mag_reg[0] == '0) || (s7_mag_reg[0] < DW'(limit));
        for (int l = 0; l < NL; l++)
        begin
            s8_next.rem[l]      = RW'(s7_mag_reg[l+1]);
            s8_next.side.neg[l] = s7_neg_reg[l+1] ^ s7_neg_reg[0];
            s8_next.side.ovf[l] = RW'(s7_mag_reg[l+1]) >= lane_div(s7_mag_reg[0], l);
        end
        for (int i = 0; i < 3; i++)
        begin
            s8_next.side.o[i] = s7_o_reg[i];
            s8_next.side.d[i] = s7_d_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // S1: origin offset
                s1_o_reg[i] <= in_o[i];
                s1_d_reg[i] <= in_d[i];
                s1_t_reg[i] <= EW'(in_o[i]) - EW'(v0[i]);
                // S2..S7: carry the ray
                s2_o_reg[i] <= s1_o_reg[i];
                s2_d_reg[i] <= s1_d_reg[i];
                s2_t_reg[i] <= s1_t_reg[i];
                s3_o_reg[i] <= s2_o_reg[i];
                s3_d_reg[i] <= s2_d_reg[i];
                s3_t_reg[i] <= s2_t_reg[i];
                s4_o_reg[i] <= s3_o_reg[i];
                s4_d_reg[i] <= s3_d_reg[i];
                s5_o_reg[i] <= s4_o_reg[i];
                s5_d_reg[i] <= s4_d_reg[i];
                s6_o_reg[i] <= s5_o_reg[i];
                s6_d_reg[i] <= s5_d_reg[i];
                s7_o_reg[i] <= s6_o_reg[i];
                s7_d_reg[i] <= s6_d_reg[i];
                // S3: cross product differences
                s3_p_reg[i] <= XW'(s2_pa_reg[i]) - XW'(s2_pb_reg[i]);
                s3_q_reg[i] <= XW'(s2_qa_reg[i]) - XW'(s2_qb_reg[i]);
            end

            // S2: cross product terms, p = D x e2, q = T x e1
            s2_pa_reg[0] <= s1_d_reg[1] * e2[2];
            s2_pb_reg[0] <= s1_d_reg[2] * e2[1];
            s2_pa_reg[1] <= s1_d_reg[2] * e2[0];
            s2_pb_reg[1] <= s1_d_reg[0] * e2[2];
            s2_pa_reg[2] <= s1_d_reg[0] * e2[1];
            s2_pb_reg[2] <= s1_d_reg[1] * e2[0];
            s2_qa_reg[0] <= s1_t_reg[1] * e1[2];
            s2_qb_reg[0] <= s1_t_reg[2] * e1[1];
            s2_qa_reg[1] <= s1_t_reg[2] * e1[0];
            s2_qb_reg[1] <= s1_t_reg[0] * e1[2];
            s2_qa_reg[2] <= s1_t_reg[0] * e1[1];
            s2_qb_reg[2] <= s1_t_reg[1] * e1[0];

            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    // S4: split multiply, low slice unsigned
                    s4_pl_reg[k][i] <= dot_a[k][i] * $signed({1'b0, dot_b[k][i][LB-1:0]});
                    s4_ph_reg[k][i] <= dot_a[k][i] * $signed(dot_b[k][i][XW-1:LB]);
                    // S5: recombine
                    s5_pr_reg[k][i] <= (PRW'(s4_ph_reg[k][i]) <<< LB)
                                       + PRW'(s4_pl_reg[k][i]);
                end
                // S6: sum of three terms
                s6_sum_reg[k] <= DW'(s5_pr_reg[k][0]) + DW'(s5_pr_reg[k][1])
                                 + DW'(s5_pr_reg[k][2]);
                // S7: sign and magnitude
                s7_neg_reg[k] <= s6_sum_reg[k][DW-1];
                s7_mag_reg[k] <= s6_sum_reg[k][DW-1] ? -s6_sum_reg[k] : s6_sum_reg[k];
            end

            s8_reg <= s8_next;
        end
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic         div_vld;
    rti_div_out_t div_out;

    rti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s8_vld_reg),
        .in_data  (s8_reg),
        .out_vld  (div_vld),
        .out_data (div_out)
    );

    // ------------------------------------------------------------------
    // classification, hit point, output register
    // ------------------------------------------------------------------
    logic                 pa_vld_reg, pb_vld_reg;
    logic                 pa_hit_reg, pb_hit_reg, out_hit_reg;
    logic [DSW-1:0]       pa_dist_reg, pb_dist_reg, out_dist_reg;
    logic signed [CW-1:0] pa_o_reg [3], pa_d_reg [3], pb_o_reg [3];
    logic signed [HMW-1:0] pb_mul_reg [3];
    logic [HW-1:0]        out_h_reg [3];

    logic [QB-1:0]  qu, qv, qt;
    logic           miss_u, miss_v, miss_t, pa_hit;
    logic [DSW-1:0] pa_dist;

    always_comb
    begin
        qu = div_out.quo[LANE_U];
        qv = div_out.quo[LANE_V];
        qt = div_out.quo[LANE_T];
        // a negative quotient that truncates to zero counts as zero
        miss_u = div_out.side.ovf[LANE_U] || (div_out.side.neg[LANE_U] && qu != '0)
                 || (qu > UV_ONE);
        miss_v = div_out.side.ovf[LANE_V] || (div_out.side.neg[LANE_V] && qv != '0)
                 || (({1'b0, qu} + {1'b0, qv}) > {1'b0, UV_ONE});
        miss_t = div_out.side.neg[LANE_T] || (!div_out.side.ovf[LANE_T] && qt == '0);
        pa_hit = !div_out.side.par_miss && !miss_u && !miss_v && !miss_t;
        pa_dist = div_out.side.ovf[LANE_T] ? DIST_MAX : DSW'(qt);
    end

    logic signed [HSW-1:0] hsum [3];
    logic [HW-1:0]         hsat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // floor of the scaled product, then saturate to 32 bits
            hsum[i] = HSW'(pb_o_reg[i]) + HSW'(pb_mul_reg[i] >>> FB);
            if ((&hsum[i][HSW-1:HW-1]) || !(|hsum[i][HSW-1:HW-1]))
            begin
                hsat[i] = hsum[i][HW-1:0];
            end
            else
            begin
                hsat[i] = hsum[i][HSW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_hit_reg  <= pa_hit;
            pa_dist_reg <= pa_hit ? pa_dist : '0;
            pb_hit_reg  <= pa_hit_reg;
            pb_dist_reg <= pa_dist_reg;
            out_hit_reg <= pb_hit_reg;
            out_dist_reg <= pb_dist_reg;
            for (int i = 0; i < 3; i++)
            begin
                pa_o_reg[i]   <= $signed(div_out.side.o[i]);
                pa_d_reg[i]   <= $signed(div_out.side.d[i]);
                pb_o_reg[i]   <= pa_o_reg[i];
                pb_mul_reg[i] <= pa_d_reg[i] * $signed({1'b0, pa_dist_reg});
                out_h_reg[i]  <= pb_hit_reg ? hsat[i] : '0;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            pa_vld_reg  <= 1'b0;
            pb_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            pa_vld_reg  <= div_vld;
            pb_vld_reg  <= pa_vld_reg;
            out_vld_reg <= pb_vld_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_h_reg[2], out_h_reg[1], out_h_reg[0],
                            out_dist_reg, out_hit_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_hit_reg |-> m_axis_tdata[ODW-1:1] == '0)
        else $error("miss result carries non-zero fields");

    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_hit_reg |-> out_dist_reg != '0)
        else $error("hit reported with zero distance");

    a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
        en && s7_vld_reg && s7_mag_reg[0] == '0 |=> s8_reg.side.par_miss)
        else $error("zero determinant not flagged as parallel");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_vld_reg)
        else $error("accepted request lost at pipeline entry");

endmodule
